// ===== rtl/brb_pkg.sv =====
package brb_pkg;

  // Widths of the stream payloads.
  localparam int COUNT_W   = 4;
  localparam int BYTES_W   = 64;
  localparam int LEVEL_W   = 8;
  localparam int MAX_LANES = 8;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 88;

  // Sequencer states, one-hot.
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_LOAD = 2'b10
  } brb_state_t;

  // Per-transfer control shared by all memory lanes.
  typedef struct packed {
    logic                wr_en;
    logic                rd_en;
    logic [COUNT_W-1:0]  count;
  } brb_ctl_t;

endpackage

// ===== rtl/byte_ring_buffer_unit.sv =====
// Byte ring FIFO with burst access. Each input transfer asks to write
// (s_tuser = 0) or read (s_tuser = 1) up to BURST_LANES bytes; the request
// is clamped to the free space or to the fill level, and one result
// transfer reports the bytes moved, the bytes read, and the fill level and
// free space afterwards. Usable capacity comes from the cfg channel (reset
// 255, limited to SLOTS - 1 and 255); a cfg write empties the FIFO and must
// only happen while the block is idle. Each item first updates the levels
// and addresses the byte lanes, then waits until the output register is free
// and moves the registered lane read into it. The output register lets the
// next item enter while a result still waits on m_tready. Bytes live in
// power-of-two lane memories indexed by a running byte sequence number, so a
// burst touches each lane at most once per transfer.
module byte_ring_buffer_unit #(
  parameter int SLOTS       = 256,
  parameter int BURST_LANES = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  // Input item: burst_count [3:0], write_bytes [67:4], zero pad [71:68].
  input  logic [brb_pkg::IN_DATA_W-1:0]     s_tdata,
  // Input kind: mode [0] (0 write, 1 read).
  input  logic                              s_tuser,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // Result: moved_count [3:0], read_bytes [67:4], fill_level [75:68],
  // free_space [83:76], zero pad [87:84].
  output logic [brb_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // Capacity register write channel.
  input  logic [brb_pkg::LEVEL_W-1:0]       cfg_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready
);

  localparam int COUNT_W   = brb_pkg::COUNT_W;
  localparam int LEVEL_W   = brb_pkg::LEVEL_W;
  // Largest ring the level counters can describe.
  localparam int RING_MAX  = ((SLOTS < 256) ? SLOTS : 256) - 1;
  localparam int SLOT_BITS = $clog2(RING_MAX + 1);
  // Lane count rounded up to a power of two, at least two.
  localparam int BANK_W    = (BURST_LANES <= 2) ? 1 : $clog2(BURST_LANES);
  localparam int NBANK     = 2**BANK_W;
  localparam int SEQ_W     = (SLOT_BITS > BANK_W) ? SLOT_BITS : BANK_W + 1;
  localparam logic [LEVEL_W-1:0] CAP_MAX = LEVEL_W'(RING_MAX);
  localparam logic [COUNT_W-1:0] LANES   = COUNT_W'(BURST_LANES);

  brb_pkg::brb_state_t state;
  brb_pkg::brb_ctl_t   ctl;

  logic [LEVEL_W-1:0] capacity;
  logic [LEVEL_W-1:0] fill;
  logic [SEQ_W-1:0]   wr_seq;
  logic [SEQ_W-1:0]   rd_seq;

  // Values held between the accept cycle and the result load.
  logic [COUNT_W-1:0] pend_count;
  logic [COUNT_W-1:0] pend_rd_count;
  logic [BANK_W-1:0]  pend_rd_low;
  logic [LEVEL_W-1:0] pend_fill;
  logic [LEVEL_W-1:0] pend_free;

  logic               accept;
  logic               mode;
  logic [COUNT_W-1:0] req;
  logic [COUNT_W-1:0] req_sat;
  logic [LEVEL_W-1:0] cap_eff;
  logic [LEVEL_W-1:0] avail;
  logic [COUNT_W-1:0] count;
  logic [LEVEL_W-1:0] fill_next;
  logic               load;

  logic [7:0]                  bank_data [NBANK];
  logic [brb_pkg::BYTES_W-1:0] read_bytes;

  assign s_tready  = (state == brb_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  assign mode      = s_tuser;
  assign req       = s_tdata[COUNT_W-1:0];
  assign load      = (state == brb_pkg::ST_LOAD) && (!m_tvalid || m_tready);

  // Clamp the request: first to the lane count, then to what the ring has.
  always_comb begin
    req_sat = (req > LANES) ? LANES : req;
    cap_eff = (capacity > CAP_MAX) ? CAP_MAX : capacity;
    avail   = mode ? fill : (cap_eff - fill);
    count   = ({{(LEVEL_W-COUNT_W){1'b0}}, req_sat} > avail) ? avail[COUNT_W-1:0]
                                                             : req_sat;
    fill_next = mode ? (fill - LEVEL_W'(count)) : (fill + LEVEL_W'(count));
    ctl.wr_en = accept && !mode;
    ctl.rd_en = accept && mode;
    ctl.count = count;
  end

  for (genvar j = 0; j < NBANK; j++) begin : g_lane
    brb_lane #(
      .BANK_W (BANK_W),
      .SEQ_W  (SEQ_W),
      .LANE   (j)
    ) u_lane (
      .clk         (clk),
      .ctl         (ctl),
      .wr_seq      (wr_seq),
      .rd_seq      (rd_seq),
      .write_bytes (s_tdata[COUNT_W +: brb_pkg::BYTES_W]),
      .rd_data     (bank_data[j])
    );
  end

  brb_merge #(
    .BANK_W (BANK_W)
  ) u_merge (
    .bank_data  (bank_data),
    .rd_low     (pend_rd_low),
    .rd_count   (pend_rd_count),
    .read_bytes (read_bytes)
  );

  // Levels, sequence numbers and the two-state sequencer. A capacity write
  // empties the FIFO; the user, not the block, keeps it off items in flight.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= brb_pkg::ST_IDLE;
      capacity <= 8'd255;
      fill     <= '0;
      wr_seq   <= '0;
      rd_seq   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
      fill     <= '0;
      wr_seq   <= '0;
      rd_seq   <= '0;
    end else begin
      case (state)
        brb_pkg::ST_IDLE: begin
          if (accept) begin
            fill  <= fill_next;
            state <= brb_pkg::ST_LOAD;
            if (mode) begin
              rd_seq <= rd_seq + SEQ_W'(count);
            end else begin
              wr_seq <= wr_seq + SEQ_W'(count);
            end
          end
        end
        brb_pkg::ST_LOAD: begin
          if (load) begin
            state <= brb_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= brb_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // Item results waiting for the lane read data.
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_count    <= count;
      pend_rd_count <= mode ? count : '0;
      pend_rd_low   <= rd_seq[BANK_W-1:0];
      pend_fill     <= fill_next;
      pend_free     <= cap_eff - fill_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {4'b0000, pend_free, pend_fill, read_bytes, pend_count};
    end
  end

endmodule

// ===== rtl/brb_lane.sv =====
module brb_lane #(
  parameter int BANK_W = 3,
  parameter int SEQ_W  = 8,
  parameter int LANE   = 0
) (
  input  logic                          clk,
  input  brb_pkg::brb_ctl_t             ctl,
  input  logic [SEQ_W-1:0]              wr_seq,
  input  logic [SEQ_W-1:0]              rd_seq,
  input  logic [brb_pkg::BYTES_W-1:0]   write_bytes,
  output logic [7:0]                    rd_data
);

  localparam int ROW_W = SEQ_W - BANK_W;
  localparam logic [BANK_W-1:0] LANE_ID = BANK_W'(LANE);

  logic [7:0]        mem [2**ROW_W];
  logic [BANK_W-1:0] wr_off;
  logic [BANK_W-1:0] rd_off;
  logic [SEQ_W-1:0]  wr_slot;
  logic [SEQ_W-1:0]  rd_slot;
  logic              wr_hit;

  // This lane holds every byte whose sequence number ends in LANE_ID.
  always_comb begin
    wr_off  = LANE_ID - wr_seq[BANK_W-1:0];
    rd_off  = LANE_ID - rd_seq[BANK_W-1:0];
    wr_slot = wr_seq + SEQ_W'(wr_off);
    rd_slot = rd_seq + SEQ_W'(rd_off);
    wr_hit  = ctl.wr_en && (brb_pkg::COUNT_W'(wr_off) < ctl.count);
  end

  always_ff @(posedge clk) begin
    if (wr_hit) begin
      mem[wr_slot[SEQ_W-1:BANK_W]] <= write_bytes[8*wr_off +: 8];
    end
    if (ctl.rd_en) begin
      rd_data <= mem[rd_slot[SEQ_W-1:BANK_W]];
    end
  end

endmodule

// ===== rtl/brb_merge.sv =====
module brb_merge #(
  parameter int BANK_W = 3
) (
  input  logic [7:0]                    bank_data [2**BANK_W],
  input  logic [BANK_W-1:0]             rd_low,
  input  logic [brb_pkg::COUNT_W-1:0]   rd_count,
  output logic [brb_pkg::BYTES_W-1:0]   read_bytes
);

  // Rotate the lane outputs so the oldest byte lands in bits 7:0.
  always_comb begin
    logic [BANK_W-1:0] src;
    read_bytes = '0;
    for (int i = 0; i < brb_pkg::MAX_LANES; i++) begin
      src = rd_low + BANK_W'(i);
      if (brb_pkg::COUNT_W'(i) < rd_count) begin
        read_bytes[8*i +: 8] = bank_data[src];
      end
    end
  end

endmodule
